[rtl/core/aes_eax_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_eax_pkg
// Types, constants and AES / GF(2^128) helper functions for the EAX unit.
// ----------------------------------------------------------------------------
package aes_eax_pkg;

  localparam logic [3:0] NR_128      = 4'd10;
  localparam logic [3:0] NR_256      = 4'd14;
  localparam logic [4:0] BLOCK_BYTES = 5'd16;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [7:0] REDUCE_POLY = 8'h87;

  localparam logic [1:0] KIND_NONCE   = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_TAG     = 2'd3;

  localparam logic [2:0] CFG_KEY_WORD0  = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD1  = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD2  = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD3  = 3'd3;
  localparam logic [2:0] CFG_KEY_IS_256 = 3'd4;

  typedef enum logic [2:0] {
    PH_NONCE      = 3'd0,
    PH_NONCE_MORE = 3'd1,
    PH_HDR        = 3'd2,
    PH_HDR_MORE   = 3'd3,
    PH_PAY        = 3'd4,
    PH_PAY_MORE   = 3'd5,
    PH_TAG        = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_L,
    ST_DBL,
    ST_CTR,
    ST_TW,
    ST_MAC,
    ST_FIN,
    ST_OUT_DATA,
    ST_OUT_TAG,
    ST_TAG_CHK,
    ST_ERR
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  // Byte 0 of the state sits in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        u[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[4 * c];
        a1 = u[4 * c + 1];
        a2 = u[4 * c + 2];
        a3 = u[4 * c + 3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        u[4 * c]     = a0 ^ x ^ xtime(a0 ^ a1);
        u[4 * c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
        u[4 * c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
        u[4 * c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = u[i] ^ k[127 - 8 * i -: 8];
    end
    return o;
  endfunction

  function automatic logic [127:0] gf_dbl(input logic [127:0] a);
    return {a[126:0], 1'b0} ^ (a[127] ? {120'd0, REDUCE_POLY} : 128'd0);
  endfunction

  // Keep the leading n bytes, zero the rest.
  function automatic logic [127:0] keep_bytes(input logic [127:0] d, input logic [4:0] n);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = (5'(i) < n) ? d[127 - 8 * i -: 8] : 8'h00;
    end
    return o;
  endfunction

  // Place the 0x80 marker right after the last valid byte (n below 16).
  function automatic logic [127:0] pad_block(input logic [127:0] d, input logic [4:0] n);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = d[127 - 8 * i -: 8] | ((5'(i) == n) ? PAD_BYTE : 8'h00);
    end
    return o;
  endfunction

endpackage

[rtl/core/aes_eax_authenticated_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_eax_authenticated_cipher_unit
// EAX authenticated encryption and decryption over AES-128 or AES-256.
// ----------------------------------------------------------------------------
// All AES work runs on one shared round unit that does one round per cycle. A
// payload item with data needs a CTR call and an OMAC call, plus one more call
// on the first block of a section for the tweak. After any key register write
// the block expands the key (one round key a cycle), computes L = AES(0) and
// both pad subkeys, and accepts no item until that is done; a key write also
// drops a message in flight. s_tready is high only while the sequencer is idle;
// a finished result waits in the output register while the next item is
// accepted. Decrypted plaintext leaves before the tag check, which arrives as
// its own result item.
// ----------------------------------------------------------------------------
module aes_eax_authenticated_cipher_unit (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // Input items.
  input  logic         s_tvalid,
  output logic         s_tready,
  // [63:0] data_hi, [127:64] data_lo, [132:128] byte_count, [133] decrypt
  input  logic [135:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  // Result items.
  output logic         m_tvalid,
  input  logic         m_tready,
  // [63:0] out_hi, [127:64] out_lo, [132:128] out_count, [133] tag_ok,
  // [134] status
  output logic [135:0] m_tdata,
  // [0] is_tag
  output logic         m_tuser,
  output logic         m_tlast
);
  import aes_eax_pkg::*;

  state_t state, state_next;
  phase_t phase;
  logic   dir;

  // Key registers and derived subkeys.
  logic [63:0]  key_word [4];
  logic         key_is_256;
  logic [127:0] rk [15];
  logic [127:0] win1, win2;
  logic [3:0]   kidx;
  logic [127:0] fpk, ppk;

  // Message state.
  logic [127:0] chain, nmac, hmac, ctr;

  // Current item.
  logic [1:0]   it_kind;
  logic [127:0] it_d;
  logic [4:0]   it_cnt;
  logic         it_last, it_first;
  logic [127:0] res_blk;

  // Shared round unit.
  logic [3:0]   rnd;
  logic [127:0] st;
  logic [3:0]   nr;
  logic         aes_state, aes_done;
  logic [127:0] aes_in, round_out;

  // Output register.
  logic [127:0] o_blk;
  logic [4:0]   o_count;
  logic         o_is_tag, o_ok, o_eor, o_status;
  logic         out_free, out_load;

  assign nr = key_is_256 ? NR_256 : NR_128;

  // Input decode and sequence check.
  logic [127:0] in_d;
  logic [4:0]   in_cnt_raw, in_cnt;
  logic [2:0]   ph_bits;
  logic [1:0]   want;
  logic         ph_first, in_err, accept, key_write;

  assign in_d       = {s_tdata[63:0], s_tdata[127:64]};
  assign in_cnt_raw = s_tdata[132:128];
  assign in_cnt     = (in_cnt_raw > BLOCK_BYTES) ? BLOCK_BYTES : in_cnt_raw;
  assign ph_bits    = phase;
  assign want       = (phase == PH_TAG) ? KIND_TAG : ph_bits[2:1];
  assign ph_first   = !ph_bits[0];
  assign in_err     = (ph_bits > 3'(PH_TAG)) || (s_tuser != want) ||
                      ((s_tuser != KIND_TAG) &&
                       ((!ph_first && in_cnt == 5'd0) ||
                        (!(ph_first && in_cnt == 5'd0) && !s_tlast && in_cnt < BLOCK_BYTES)));
  assign accept     = s_tvalid && s_tready;
  assign key_write  = cfg_we && (cfg_index <= CFG_KEY_IS_256);

  logic it_empty, it_done;
  assign it_empty = it_first && (it_cnt == 5'd0);
  assign it_done  = it_empty || it_last;

  // Key schedule step: one 128-bit round key per cycle from the last one or two.
  logic [31:0]  kt_in, kt;
  logic [127:0] kbase, kval;
  logic [31:0]  w0, w1, w2, w3;
  logic         use_rot;
  logic [7:0]   rc;

  always_comb begin
    kt_in   = win1[31:0];
    use_rot = !key_is_256 || !kidx[0];
    rc      = key_is_256 ? rcon({1'b0, kidx[3:1]}) : rcon(kidx);
    kt      = use_rot ? (sub_word({kt_in[23:0], kt_in[31:24]}) ^ {rc, 24'd0})
                      : sub_word(kt_in);
    kbase   = key_is_256 ? win2 : win1;
    w0      = kbase[127:96] ^ kt;
    w1      = kbase[95:64] ^ w0;
    w2      = kbase[63:32] ^ w1;
    w3      = kbase[31:0] ^ w2;
    if (kidx == 4'd0) begin
      kval = {key_word[0], key_word[1]};
    end else if (kidx == 4'd1 && key_is_256) begin
      kval = {key_word[2], key_word[3]};
    end else begin
      kval = {w0, w1, w2, w3};
    end
  end

  // Round unit: the first cycle of a call adds round key 0, each later cycle
  // does one full round; the last round skips MixColumns.
  assign round_out = aes_round(st, rk[rnd], rnd != nr);
  assign aes_state = (state == ST_L) || (state == ST_CTR) || (state == ST_TW) ||
                     (state == ST_MAC);
  assign aes_done  = aes_state && (rnd == nr);
  assign out_free  = !m_tvalid || m_tready;
  // A result is loaded into the output register in any of the output states once the register is free.
  assign out_load  = out_free && ((state == ST_OUT_DATA) || (state == ST_OUT_TAG) ||
                                  (state == ST_TAG_CHK) || (state == ST_ERR));

  // MAC block: the last block of a section carries a subkey, plus padding when it is not full.
  logic [127:0] mac_blk;
  always_comb begin
    if (!it_last) begin
      mac_blk = it_d;
    end else if (it_cnt >= BLOCK_BYTES) begin
      mac_blk = it_d ^ fpk;
    end else begin
      mac_blk = pad_block(it_d, it_cnt) ^ ppk;
    end
  end

  // Control outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    case (state)
      ST_CTR:  aes_in = ctr;
      ST_TW:   aes_in = {126'd0, it_kind} ^ (it_empty ? fpk : 128'd0);
      ST_MAC:  aes_in = chain ^ mac_blk;
      default: aes_in = 128'd0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_err) begin
            state_next = ST_ERR;
          end else if (s_tuser == KIND_TAG) begin
            state_next = ST_TAG_CHK;
          end else if (s_tuser == KIND_PAYLOAD && in_cnt != 5'd0) begin
            state_next = ST_CTR;
          end else if (ph_first) begin
            state_next = ST_TW;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      ST_KEY:      if (kidx == nr) state_next = ST_L;
      ST_L:        if (aes_done) state_next = ST_DBL;
      ST_DBL:      state_next = ST_IDLE;
      ST_CTR:      if (aes_done) state_next = it_first ? ST_TW : ST_MAC;
      ST_TW:       if (aes_done) state_next = it_empty ? ST_FIN : ST_MAC;
      ST_MAC:      if (aes_done) state_next = ST_FIN;
      ST_FIN: begin
        if (it_kind == KIND_PAYLOAD && it_cnt != 5'd0) begin
          state_next = ST_OUT_DATA;
        end else if (it_kind == KIND_PAYLOAD && it_done && !dir) begin
          state_next = ST_OUT_TAG;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT_DATA: if (out_free) state_next = (it_done && !dir) ? ST_OUT_TAG : ST_IDLE;
      ST_OUT_TAG:  if (out_free) state_next = ST_IDLE;
      ST_TAG_CHK:  if (out_free) state_next = ST_IDLE;
      ST_ERR:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
    if (key_write) begin
      state_next = ST_KEY;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_NONCE;
      dir        <= 1'b0;
      key_word   <= '{default: 64'd0};
      key_is_256 <= 1'b0;
      fpk        <= 128'd0;
      ppk        <= 128'd0;
      chain      <= 128'd0;
      nmac       <= 128'd0;
      hmac       <= 128'd0;
      ctr        <= 128'd0;
      kidx       <= 4'd0;
      rnd        <= 4'd0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (aes_state) begin
        rnd <= aes_done ? 4'd0 : rnd + 4'd1;
      end else begin
        rnd <= 4'd0;
      end

      if (key_write) begin
        // A key write restarts the key expansion and drops any open message.
        kidx  <= 4'd0;
        phase <= PH_NONCE;
      end else begin
        if (state == ST_KEY) begin
          kidx <= kidx + 4'd1;
        end

        case (state)
          ST_IDLE: begin
            if (accept && !in_err && s_tuser == KIND_NONCE && ph_first) begin
              dir <= s_tdata[133];
            end
          end
          ST_L:   if (aes_done) fpk <= gf_dbl(round_out);
          ST_DBL: ppk <= gf_dbl(fpk);
          ST_CTR: if (aes_done) ctr <= ctr + 128'd1;
          ST_TW:  if (aes_done) chain <= round_out;
          ST_MAC: if (aes_done) chain <= round_out;
          ST_FIN: begin
            case (it_kind)
              KIND_NONCE: begin
                if (it_done) begin
                  nmac  <= chain;
                  ctr   <= chain;
                  phase <= PH_HDR;
                end else begin
                  phase <= PH_NONCE_MORE;
                end
              end
              KIND_HEADER: begin
                if (it_done) begin
                  hmac  <= chain;
                  phase <= PH_PAY;
                end else begin
                  phase <= PH_HDR_MORE;
                end
              end
              default: begin
                if (it_done) begin
                  // The tag replaces the chain: it is sent out or compared.
                  chain <= chain ^ nmac ^ hmac;
                  phase <= dir ? PH_TAG : PH_NONCE;
                end else begin
                  phase <= PH_PAY_MORE;
                end
              end
            endcase
          end
          ST_TAG_CHK: begin
            if (out_free) begin
              phase <= PH_NONCE;
            end
          end
          default: ;
        endcase
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_WORD0:  key_word[0] <= cfg_data;
          CFG_KEY_WORD1:  key_word[1] <= cfg_data;
          CFG_KEY_WORD2:  key_word[2] <= cfg_data;
          CFG_KEY_WORD3:  key_word[3] <= cfg_data;
          CFG_KEY_IS_256: key_is_256  <= cfg_data[0];
          default:        ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_KEY) begin
      rk[kidx] <= kval;
      win2     <= win1;
      win1     <= kval;
    end

    if (aes_state) begin
      st <= (rnd == 4'd0) ? (aes_in ^ rk[0]) : round_out;
    end

    if (accept) begin
      it_kind  <= s_tuser;
      it_cnt   <= in_cnt;
      it_last  <= s_tlast;
      it_first <= ph_first;
      it_d     <= (s_tuser == KIND_TAG) ? in_d : keep_bytes(in_d, in_cnt);
    end

    if (state == ST_CTR && aes_done) begin
      res_blk <= keep_bytes(it_d ^ round_out, it_cnt);
      // When encrypting, the OMAC covers the ciphertext just made.
      if (!dir) begin
        it_d <= keep_bytes(it_d ^ round_out, it_cnt);
      end
    end

    if (out_free) begin
      case (state)
        ST_OUT_DATA: begin
          o_blk    <= res_blk;
          o_count  <= it_cnt;
          o_is_tag <= 1'b0;
          o_ok     <= 1'b0;
          o_eor    <= !(it_done && !dir);
          o_status <= 1'b0;
        end
        ST_OUT_TAG: begin
          o_blk    <= chain;
          o_count  <= BLOCK_BYTES;
          o_is_tag <= 1'b1;
          o_ok     <= 1'b0;
          o_eor    <= 1'b1;
          o_status <= 1'b0;
        end
        ST_TAG_CHK: begin
          o_blk    <= 128'd0;
          o_count  <= 5'd0;
          o_is_tag <= 1'b1;
          o_ok     <= (it_d == chain);
          o_eor    <= 1'b1;
          o_status <= 1'b0;
        end
        ST_ERR: begin
          o_blk    <= 128'd0;
          o_count  <= 5'd0;
          o_is_tag <= 1'b0;
          o_ok     <= 1'b0;
          o_eor    <= 1'b1;
          o_status <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {1'b0, o_status, o_ok, o_count, o_blk[63:0], o_blk[127:64]};
  assign m_tuser = o_is_tag;
  assign m_tlast = o_eor;

  // The round counter never runs past the last round of the selected key size.
  a_rnd_bound: assert property (@(posedge clk) disable iff (rst) rnd <= nr)
    else $error("round counter beyond last round");

  // Key expansion never writes past the last round key.
  a_kidx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEY) |-> (kidx <= nr))
    else $error("key expansion index beyond last round key");

  // An encryption tag is sent only after the message has closed.
  a_tag_phase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_TAG) |-> (phase == PH_NONCE && !dir))
    else $error("tag emitted with message still open");

  // Subkey derivation returns to idle unless another key write arrives.
  a_dbl_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DBL && !key_write) |=> (state == ST_IDLE))
    else $error("derivation did not finish");

endmodule
